>>> hw/rtl/mcrr_pkg.sv
// Package with beat types, status codes and binomial helpers for the rank/unrank core.
`timescale 1ns / 1ps

package mcrr_pkg;

  localparam int DefaultCells = 25;
  localparam int MaskW        = 25;
  localparam int RankW        = 23;
  localparam int SizeW        = 5;
  localparam int MaxTbl       = 64;

  localparam logic [RankW-1:0] RankMax = {RankW{1'b1}};

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_COUNT    = 2'd1,
    STATUS_EXCLUDED = 2'd2,
    STATUS_RANGE    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RANK_END,
    ST_TOTAL_RD,
    ST_TOTAL_CHK,
    ST_DESC_RD,
    ST_DESC_CMP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             req_type;
    logic [MaskW-1:0] cell_mask;
    logic [MaskW-1:0] excluded_mask;
    logic [SizeW-1:0] set_size;
    logic [RankW-1:0] rank_in;
  } req_t;

  typedef struct packed {
    logic [RankW-1:0] rank_out;
    logic [MaskW-1:0] cells_out;
    status_e          status;
  } rsp_t;

  // Binomial coefficient built from Pascal's rule, for use at elaboration only.
  function automatic longint binom_f(int n, int j);
    longint row [MaxTbl];
    longint res;
    for (int x = 0; x < MaxTbl; x++) begin
      row[x] = 0;
    end
    row[0] = 1;
    for (int m = 1; m <= n; m++) begin
      for (int x = m; x >= 1; x--) begin
        row[x] = row[x] + row[x-1];
      end
    end
    res = (j > n || j < 0 || j >= MaxTbl) ? 64'd0 : row[j];
    return res;
  endfunction

  // Largest entry of the given row, which is the largest entry of the whole table.
  function automatic longint max_binom_f(int n);
    longint best;
    best = 1;
    for (int j = 0; j <= n; j++) begin
      if (binom_f(n, j) > best) begin
        best = binom_f(n, j);
      end
    end
    return best;
  endfunction

endpackage

>>> hw/rtl/masked_combination_rank_unrank_core.sv
// Masked combinatorial-number-system rank and unrank core with a shared binomial ROM.
`timescale 1ns / 1ps
// Rank requests scan one board cell per cycle, then pass through RANK_END and FINISH.
// Unrank requests run the scan, a total read and check, then a descending pass with a read
// and a compare state per non-excluded cell, as the single registered ROM read port needs.
// One request is in flight at a time; the output register frees the core while a result waits.
// Reset is asynchronous and active low and returns the core to idle with no result pending.
module masked_combination_rank_unrank_core #(
  parameter int CELLS = mcrr_pkg::DefaultCells
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mcrr_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mcrr_pkg::rsp_t out_rsp_o
);

  import mcrr_pkg::*;

  localparam int Tbl   = CELLS + 1;
  localparam int Depth = Tbl * Tbl;
  localparam int AW    = $clog2(Depth);
  localparam int IW    = $clog2(Tbl);
  localparam int CW    = $clog2(CELLS);
  localparam int BW    = $clog2(max_binom_f(CELLS) + 1);
  localparam int SW    = (BW > RankW) ? BW : RankW;

  typedef logic [BW-1:0] rom_t [Depth];

  function automatic rom_t rom_init_f();
    rom_t t;
    for (int n = 0; n < Tbl; n++) begin
      for (int j = 0; j < Tbl; j++) begin
        t[n*Tbl+j] = BW'(binom_f(n, j));
      end
    end
    return t;
  endfunction

  localparam rom_t Rom = rom_init_f();

  function automatic logic [AW-1:0] addr_f(logic [IW-1:0] n, logic [IW-1:0] j);
    return AW'(n) * AW'(Tbl) + AW'(j);
  endfunction

  state_e            state_q, state_d;
  logic              req_q, req_d;
  logic [CELLS-1:0]  cm_q, cm_d, ex_q, ex_d, mask_q, mask_d;
  logic [SizeW-1:0]  k_q, k_d;
  logic [CW-1:0]     c_q, c_d;
  logic [IW-1:0]     f_q, f_d, cnt_q, cnt_d, pos_q, pos_d, i_q, i_d;
  logic [SW-1:0]     sum_q, sum_d, r_q, r_d;
  logic              excl_q, excl_d, err_q, err_d, add_q, add_d;
  logic [AW-1:0]     rom_addr;
  logic [BW-1:0]     rom_q;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_rsp_q, out_rsp_d;
  logic              cm_bit, ex_bit, k_big, last_asc, out_free, rom_fits;

  assign cm_bit   = cm_q[c_q];
  assign ex_bit   = ex_q[c_q];
  assign k_big    = int'(k_q) > CELLS;
  assign last_asc = (int'(c_q) == CELLS - 1);
  assign out_free = !out_valid_q || out_ready_i;
  assign rom_fits = SW'(rom_q) <= r_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:      if (last_asc) state_d = req_q ? ST_TOTAL_RD : ST_RANK_END;
      ST_RANK_END:  state_d = ST_FINISH;
      ST_TOTAL_RD:  state_d = ST_TOTAL_CHK;
      ST_TOTAL_CHK: state_d = (k_big || r_q >= SW'(rom_q)) ? ST_FINISH : ST_DESC_RD;
      ST_DESC_RD: begin
        if (ex_bit) begin
          state_d = (c_q == '0) ? ST_FINISH : ST_DESC_RD;
        end else if (i_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_DESC_CMP;
        end
      end
      ST_DESC_CMP:  state_d = (c_q == '0) ? ST_FINISH : ST_DESC_RD;
      ST_FINISH:    if (out_free) state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_d       = req_q;
    cm_d        = cm_q;
    ex_d        = ex_q;
    mask_d      = mask_q;
    k_d         = k_q;
    c_d         = c_q;
    f_d         = f_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    i_d         = i_q;
    r_d         = r_q;
    excl_d      = excl_q;
    err_d       = err_q;
    add_d       = 1'b0;
    rom_addr    = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    sum_d       = add_q ? sum_q + SW'(rom_q) : sum_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_req_i.req_type;
          cm_d   = CELLS'(in_req_i.cell_mask);
          ex_d   = CELLS'(in_req_i.excluded_mask);
          k_d    = in_req_i.set_size;
          r_d    = SW'(in_req_i.rank_in);
          mask_d = '0;
          c_d    = '0;
          f_d    = '0;
          cnt_d  = '0;
          sum_d  = '0;
          excl_d = 1'b0;
          err_d  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (!ex_bit) begin
          f_d = f_q + 1'b1;
          if (cm_bit) begin
            rom_addr = addr_f(f_q, cnt_q + 1'b1);
            add_d    = 1'b1;
          end
        end else if (cm_bit) begin
          excl_d = 1'b1;
        end
        if (cm_bit) cnt_d = cnt_q + 1'b1;
        c_d = c_q + 1'b1;
      end
      ST_RANK_END: begin
      end
      ST_TOTAL_RD: begin
        rom_addr = addr_f(f_q, IW'(k_q));
      end
      ST_TOTAL_CHK: begin
        if (k_big || r_q >= SW'(rom_q)) begin
          err_d = 1'b1;
        end else begin
          c_d   = CW'(CELLS - 1);
          pos_d = f_q;
          i_d   = IW'(k_q);
        end
      end
      ST_DESC_RD: begin
        if (!ex_bit && i_q != '0) begin
          rom_addr = addr_f(pos_q - 1'b1, i_q);
        end else if (ex_bit && c_q != '0) begin
          c_d = c_q - 1'b1;
        end
      end
      ST_DESC_CMP: begin
        if (rom_fits) begin
          mask_d[c_q] = 1'b1;
          r_d         = r_q - SW'(rom_q);
          i_d         = i_q - 1'b1;
        end
        pos_d = pos_q - 1'b1;
        if (c_q != '0) c_d = c_q - 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_rsp_d.rank_out  = '0;
          out_rsp_d.cells_out = '0;
          out_rsp_d.status    = STATUS_OK;
          if (req_q) begin
            if (err_q) begin
              out_rsp_d.status = STATUS_RANGE;
            end else begin
              out_rsp_d.cells_out = MaskW'(mask_q);
            end
          end else if (int'(cnt_q) != int'(k_q)) begin
            out_rsp_d.status = STATUS_COUNT;
          end else if (excl_q) begin
            out_rsp_d.status = STATUS_EXCLUDED;
          end else begin
            out_rsp_d.rank_out = (sum_q > SW'(RankMax)) ? RankMax : RankW'(sum_q);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rom_q <= Rom[rom_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      add_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      add_q       <= add_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cm_q      <= cm_d;
    ex_q      <= ex_d;
    mask_q    <= mask_d;
    k_q       <= k_d;
    c_q       <= c_d;
    f_q       <= f_d;
    cnt_q     <= cnt_d;
    pos_q     <= pos_d;
    i_q       <= i_d;
    r_q       <= r_d;
    sum_q     <= sum_d;
    excl_q    <= excl_d;
    err_q     <= err_d;
    out_rsp_q <= out_rsp_d;
  end

endmodule

>>> hw/rtl/mcrr_checker.sv
// Port-level checker for the rank/unrank core, bound to the core module.
`timescale 1ns / 1ps

module mcrr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input mcrr_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input mcrr_pkg::rsp_t out_rsp_o
);

  import mcrr_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("Result beat changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Core took a new beat while busy.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != STATUS_OK |->
      out_rsp_o.rank_out == '0 && out_rsp_o.cells_out == '0)
    else $error("Error result carries a nonzero payload.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.rank_out == '0 || out_rsp_o.cells_out == '0)
    else $error("Result carries both a rank and a cell mask.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("Result appeared one cycle after the request.");

endmodule

bind masked_combination_rank_unrank_core mcrr_checker u_mcrr_checker (.*);
